@@ rtl/encoder_direction_speed_meter_macros.svh @@
// assertion helpers used by the checker file
`ifndef ENCODER_DIRECTION_SPEED_METER_MACROS_SVH
`define ENCODER_DIRECTION_SPEED_METER_MACROS_SVH

// clocked check, quiet while reset is asserted
`define EDSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define EDSM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/edsm_pkg.sv @@
package edsm_pkg;

  localparam int unsigned PULSES_PER_REV_DEF   = 1024;
  localparam int unsigned TICKS_PER_SECOND_DEF = 1000000;

  // 2*pi in unsigned q32, rounded down
  localparam logic [63:0] TWO_PI_Q32 = 64'd26986075409;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned INTERVAL_W = 24;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned Q_FRAC_W   = 16;

  localparam logic REG_LEFT_SIDE = 1'b0;

  localparam logic KIND_ENC   = 1'b0;
  localparam logic KIND_SPEED = 1'b1;

  localparam logic [DATA_W-1:0] COUNT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] COUNT_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_MUL,
    SEQ_DIV,
    SEQ_DONE
  } seq_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

endpackage

@@ rtl/edsm_alu.sv @@
module edsm_alu #(
  parameter int unsigned WIDTH = 64
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic             sub_i,
  output logic [WIDTH-1:0] sum_o,
  output logic             carry_o
);

  logic [WIDTH:0] full;

  // subtract as a plus inverted b plus one; carry set means a >= b
  assign full    = {1'b0, a_i} + {1'b0, b_i ^ {WIDTH{sub_i}}} + {{WIDTH{1'b0}}, sub_i};
  assign sum_o   = full[WIDTH-1:0];
  assign carry_o = full[WIDTH];

endmodule

@@ rtl/edsm_speed_seq.sv @@
module edsm_speed_seq #(
  parameter int unsigned PULSES_PER_REV   = edsm_pkg::PULSES_PER_REV_DEF,
  parameter int unsigned TICKS_PER_SECOND = edsm_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [edsm_pkg::DATA_W-1:0]         count_i,
  input  logic [edsm_pkg::INTERVAL_W-1:0]     ticks_i,
  output edsm_pkg::seq_stat_t                 stat_o,
  output logic [edsm_pkg::DATA_W-1:0]         speed_o
);

  import edsm_pkg::*;

  localparam logic [63:0] K   = 64'(TICKS_PER_SECOND) * TWO_PI_Q32;
  localparam int unsigned KW  = $clog2(K + 64'd1);
  localparam int unsigned NW  = DATA_W + KW;
  localparam int unsigned PDW = $clog2(PULSES_PER_REV + 1) + INTERVAL_W;
  localparam int unsigned DW  = PDW + Q_FRAC_W;
  localparam int unsigned RW  = DW + 1;
  localparam int unsigned AW  = (NW > RW) ? NW : RW;
  localparam int unsigned CW  = $clog2(NW);

  seq_state_e state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DATA_W-1:0] mag_q, mag_d;
  logic              neg_q, neg_d;
  logic [DW-1:0]     den_q, den_d;
  logic [NW-1:0]     acc_q, acc_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic              ovf_q, ovf_d;

  logic [AW-1:0] alu_a, alu_b, alu_sum;
  logic          alu_sub, alu_carry;
  logic [RW-1:0] rem_sh;
  logic          sat;

  edsm_alu #(.WIDTH(AW)) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  assign rem_sh = {rem_q[RW-2:0], acc_q[NW-1]};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    den_d   = den_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    ovf_d   = ovf_q;
    alu_a   = AW'({acc_q[NW-2:0], 1'b0});
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      SEQ_IDLE: begin
        if (start_i) begin
          neg_d   = count_i[DATA_W-1];
          mag_d   = count_i[DATA_W-1] ? (~count_i + 32'd1) : count_i;
          den_d   = {PDW'(PULSES_PER_REV) * PDW'(ticks_i), {Q_FRAC_W{1'b0}}};
          acc_d   = '0;
          cnt_d   = CW'(DATA_W - 1);
          state_d = SEQ_MUL;
        end
      end
      SEQ_MUL: begin
        // shift-add, magnitude msb first
        alu_b = mag_q[DATA_W-1] ? AW'(K) : '0;
        acc_d = alu_sum[NW-1:0];
        mag_d = {mag_q[DATA_W-2:0], 1'b0};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          cnt_d   = CW'(NW - 1);
          rem_d   = '0;
          quo_d   = '0;
          ovf_d   = 1'b0;
          state_d = SEQ_DIV;
        end
      end
      SEQ_DIV: begin
        // restoring division, one numerator bit per cycle
        alu_a   = AW'(rem_sh);
        alu_b   = AW'(den_q);
        alu_sub = 1'b1;
        rem_d   = alu_carry ? alu_sum[RW-1:0] : rem_sh;
        acc_d   = {acc_q[NW-2:0], 1'b0};
        quo_d   = {quo_q[DATA_W-2:0], alu_carry};
        ovf_d   = ovf_q | quo_q[DATA_W-1];
        cnt_d   = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        state_d = SEQ_IDLE;
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    den_q <= den_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  // quotient of 2^31 or more saturates either way
  assign sat = ovf_q | quo_q[DATA_W-1];

  always_comb begin
    if (sat) begin
      speed_o = neg_q ? COUNT_MIN : COUNT_MAX;
    end else begin
      speed_o = neg_q ? (~quo_q + 32'd1) : quo_q;
    end
  end

  assign stat_o.busy = (state_q != SEQ_IDLE);
  assign stat_o.done = (state_q == SEQ_DONE);

endmodule

@@ rtl/encoder_direction_speed_meter.sv @@
// encoder event or zero-interval sample: registered result in the next cycle, one item per cycle
// speed sample: 32 shift-add steps plus 32+bit length of TICKS_PER_SECOND*2pi*2^32 divide steps
// on the shared adder, after which the done state loads the result into the output register
// the block takes no item while the speed sequencer runs or an unread result is stalled
// async active-low reset: count 0, forward, not primed, speed 0, left_side 0, output empty
module encoder_direction_speed_meter #(
  parameter int unsigned PULSES_PER_REV   = edsm_pkg::PULSES_PER_REV_DEF,
  parameter int unsigned TICKS_PER_SECOND = edsm_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            kind_i,
  input  logic                            enc_a_i,
  input  logic                            enc_b_i,
  input  logic [edsm_pkg::INTERVAL_W-1:0] interval_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [edsm_pkg::DATA_W-1:0]     pulse_count_o,
  output logic                            forward_o,
  output logic [edsm_pkg::DATA_W-1:0]     speed_o,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [edsm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [edsm_pkg::DATA_W-1:0]     pwdata,
  output logic [edsm_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);

  import edsm_pkg::*;

  // configuration
  logic left_side_q;
  logic cfg_wr;

  // encoder and speed state
  logic [DATA_W-1:0] count_q, count_d;
  logic              dir_q, dir_d;
  logic              last_a_q, last_a_d;
  logic              primed_q, primed_d;
  logic [DATA_W-1:0] speed_q, speed_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_count_q;
  logic              out_fwd_q;
  logic [DATA_W-1:0] out_speed_q;
  logic              out_load;

  logic              accept;
  logic              start;
  seq_stat_t         seq_stat;
  logic [DATA_W-1:0] seq_speed;

  // apb: register sits at word zero, pready is tied high
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_LEFT_SIDE) ? {{(DATA_W-1){1'b0}}, left_side_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_side_q <= 1'b0;
    end else if (cfg_wr && paddr[2] == REG_LEFT_SIDE) begin
      left_side_q <= pwdata[0];
    end
  end

  // a new request only when the sequencer is free and the output slot frees up
  assign in_ready_o = !seq_stat.busy && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign start      = accept && (kind_i == KIND_SPEED) && (interval_i != '0);

  edsm_speed_seq #(
    .PULSES_PER_REV   (PULSES_PER_REV),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .count_i (count_q),
    .ticks_i (interval_i),
    .stat_o  (seq_stat),
    .speed_o (seq_speed)
  );

  always_comb begin
    count_d  = count_q;
    dir_d    = dir_q;
    last_a_d = last_a_q;
    primed_d = primed_q;
    speed_d  = speed_q;
    out_load = 1'b0;
    if (accept) begin
      if (kind_i == KIND_ENC) begin
        out_load = 1'b1;
        if (!primed_q) begin
          // very first event only records the A level
          last_a_d = enc_a_i;
          primed_d = 1'b1;
        end else begin
          if (!last_a_q && enc_a_i) begin
            // rising edge of A: B low means forward, swapped on the left side
            dir_d = left_side_q ? enc_b_i : !enc_b_i;
          end
          last_a_d = enc_a_i;
          if (dir_d) begin
            if (count_q != COUNT_MAX) begin
              count_d = count_q + 32'd1;
            end
          end else begin
            if (count_q != COUNT_MIN) begin
              count_d = count_q - 32'd1;
            end
          end
        end
      end else if (interval_i == '0) begin
        // zero interval just reports the current state
        out_load = 1'b1;
      end
    end
    if (seq_stat.done) begin
      speed_d  = seq_speed;
      count_d  = '0;
      out_load = 1'b1;
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dir_q       <= 1'b1;
      last_a_q    <= 1'b0;
      primed_q    <= 1'b0;
      speed_q     <= '0;
      out_valid_q <= 1'b0;
      out_count_q <= '0;
      out_fwd_q   <= 1'b1;
      out_speed_q <= '0;
    end else begin
      count_q     <= count_d;
      dir_q       <= dir_d;
      last_a_q    <= last_a_d;
      primed_q    <= primed_d;
      speed_q     <= speed_d;
      out_valid_q <= out_valid_d;
      if (out_load) begin
        out_count_q <= count_d;
        out_fwd_q   <= dir_d;
        out_speed_q <= speed_d;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pulse_count_o = out_count_q;
  assign forward_o     = out_fwd_q;
  assign speed_o       = out_speed_q;

endmodule

@@ rtl/edsm_checker.sv @@
`include "encoder_direction_speed_meter_macros.svh"

module edsm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            kind_i,
  input logic [edsm_pkg::INTERVAL_W-1:0] interval_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [edsm_pkg::DATA_W-1:0]     pulse_count_o,
  input logic                            forward_o,
  input logic [edsm_pkg::DATA_W-1:0]     speed_o,
  input logic                            pready
);

  import edsm_pkg::*;

  logic                in_take;
  logic                out_stall;
  logic                zero_take;
  logic [2*DATA_W:0]   res_cat;

  assign in_take   = in_valid_i & in_ready_o;
  assign out_stall = out_valid_o & !out_ready_i;
  assign zero_take = in_take && kind_i == KIND_SPEED && interval_i == '0;
  assign res_cat   = {pulse_count_o, forward_o, speed_o};

  // a stalled result is never dropped
  `EDSM_ASSERT(a_out_hold, out_stall |=> out_valid_o, "result dropped")

  // no new request while a result waits and is not taken
  `EDSM_ASSERT(a_no_accept_stalled, out_stall |-> !in_ready_o, "accept while stalled")

  // an encoder event answers in the next cycle
  `EDSM_ASSERT(a_enc_one_cycle, in_take && kind_i == KIND_ENC |=> out_valid_o, "encoder event late")

  // a zero-interval sample reports the previous state unchanged
  `EDSM_ASSERT(a_zero_interval, zero_take |=> out_valid_o && res_cat == $past(res_cat), "zero interval changed state")

  `EDSM_ASSERT_ALWAYS(a_pready_high, pready, "pready low")

endmodule

bind encoder_direction_speed_meter edsm_checker u_edsm_checker (.*);
